/* src/onre_pkg.sv */
// Package for the Oren-Nayar evaluator: widths, constants, register codes and pipeline side types.
package onre_pkg;

    // direction fraction bits and the derived widths
    localparam int DIR_FRAC_BITS = 15;
    localparam int F         = DIR_FRAC_BITS;
    localparam int DIR_W     = 16;
    localparam int ONE_W     = F + 1;
    localparam int SQ_W      = 2 * ONE_W;
    localparam int RAD_W     = 2 * F;
    localparam int ROOT_W    = F;
    localparam int PROD_W    = 2 * DIR_W;
    localparam int DOT_W     = PROD_W + 1;
    localparam int QUO_W     = F + 1;
    localparam int NP_W      = DOT_W - 1 + F;
    localparam int DP_W      = 2 * F;
    localparam int NQ_W      = 2 * F;
    localparam int DQ_W      = ONE_W;
    localparam int CPW_W     = ONE_W + F;
    localparam int COEF_A_W  = 16;
    localparam int COEF_B_W  = 14;
    localparam int REFL_W    = 16;
    localparam int ACO_W     = COEF_A_W + ONE_W;
    localparam int BT_W      = COEF_B_W + ONE_W;
    localparam int SUM_W     = ACO_W + 1;
    localparam int R_W       = SUM_W - F;
    localparam int M1_W      = REFL_W + R_W;
    localparam int INV_PI_W  = 31;
    localparam int M2_W      = M1_W + INV_PI_W;
    localparam int VAL_SHIFT = 47;
    localparam int VRAW_W    = M2_W - VAL_SHIFT;
    localparam int DSUM_W    = ONE_W + INV_PI_W + 1;
    localparam int DEN_SHIFT = F + 16;
    localparam int DRAW_W    = DSUM_W - DEN_SHIFT;
    localparam int VAL_W     = 16;
    localparam int APB_ADDR_W = 5;
    localparam int APB_DATA_W = 32;

    localparam logic [ONE_W-1:0]    ONE    = ONE_W'(1) << F;
    localparam logic [SQ_W-1:0]     ONE_SQ = SQ_W'(1) << (2 * F);
    localparam logic [INV_PI_W-1:0] INV_PI = 31'd1367130551;
    localparam logic [VAL_W-1:0]    VAL_MAX = '1;

    // register indexes (byte address / 4)
    typedef enum logic [2:0] {
        REG_COEF_A     = 3'd0,
        REG_COEF_B     = 3'd1,
        REG_REFL_RED   = 3'd2,
        REG_REFL_GREEN = 3'd3,
        REG_REFL_BLUE  = 3'd4
    } reg_idx_t;

    // side data through the square-root chain
    typedef struct packed {
        logic [ONE_W-1:0]        ci;
        logic [ONE_W-1:0]        co;
        logic signed [DOT_W-1:0] dot;
        logic [VAL_W-1:0]        dens;
        logic                    ok;
    } sq_side_t;

    // side data through the divider chain
    typedef struct packed {
        logic [ONE_W-1:0] co;
        logic [VAL_W-1:0] dens;
        logic             ok;
        logic             cp_ok;
        logic             sat;
    } dv_side_t;

    // side data through the back end
    typedef struct packed {
        logic [VAL_W-1:0] dens;
        logic             ok;
    } tail_t;

endpackage

/* src/oren_nayar_reflectance_eval.sv */
// Oren-Nayar reflectance evaluator top level: APB registers, pipeline and cell chains.
//
// Takes one item per clock unless the output is held, and returns one result per
// item, in order. The pipeline is built around two chains of bit cells: a 15-cell
// square-root chain (both polar sines side by side, one root bit per cell) and a
// 16-cell restoring divider chain (azimuth cosine and the alpha/beta weight side by
// side, one quotient bit per cell), plus ten single-stage multiply and add
// steps around them. The whole pipeline holds while a result waits on m_tready,
// so input is taken in every cycle in which the output register is free or
// drained. Coefficients and reflectances are read by the pipeline directly and
// must only be written while no item is in flight.
module oren_nayar_reflectance_eval (
    input  logic                                aclk,
    input  logic                                aresetn,
    // APB configuration
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [onre_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [onre_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [onre_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                pready,
    // input items
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // in_dir_x, in_dir_y, in_dir_z, out_dir_x, out_dir_y, out_dir_z (16 b each)
    input  logic [95:0]                         s_tdata,
    // solid_angle
    input  logic [0:0]                          s_tuser,
    // result items
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // value_red, value_green, value_blue, density (16 b each)
    output logic [63:0]                         m_tdata
);

    localparam int F      = onre_pkg::F;
    localparam int ONE_W  = onre_pkg::ONE_W;
    localparam int RAD_W  = onre_pkg::RAD_W;
    localparam int ROOT_W = onre_pkg::ROOT_W;
    localparam int DOT_W  = onre_pkg::DOT_W;
    localparam int QUO_W  = onre_pkg::QUO_W;
    localparam int NP_W   = onre_pkg::NP_W;
    localparam int DP_W   = onre_pkg::DP_W;
    localparam int NQ_W   = onre_pkg::NQ_W;
    localparam int DQ_W   = onre_pkg::DQ_W;
    localparam int VAL_W  = onre_pkg::VAL_W;

    // ---------------- configuration registers ----------------
    logic [onre_pkg::COEF_A_W-1:0] coef_a_reg;
    logic [onre_pkg::COEF_B_W-1:0] coef_b_reg;
    logic [onre_pkg::REFL_W-1:0]   refl_reg [0:2];
    logic                          cfg_wr;
    onre_pkg::reg_idx_t            cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = onre_pkg::reg_idx_t'(paddr[onre_pkg::APB_ADDR_W-1:2]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            coef_a_reg  <= onre_pkg::COEF_A_W'(32768);
            coef_b_reg  <= '0;
            refl_reg[0] <= '1;
            refl_reg[1] <= '1;
            refl_reg[2] <= '1;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                onre_pkg::REG_COEF_A:     coef_a_reg  <= pwdata[onre_pkg::COEF_A_W-1:0];
                onre_pkg::REG_COEF_B:     coef_b_reg  <= pwdata[onre_pkg::COEF_B_W-1:0];
                onre_pkg::REG_REFL_RED:   refl_reg[0] <= pwdata[onre_pkg::REFL_W-1:0];
                onre_pkg::REG_REFL_GREEN: refl_reg[1] <= pwdata[onre_pkg::REFL_W-1:0];
                onre_pkg::REG_REFL_BLUE:  refl_reg[2] <= pwdata[onre_pkg::REFL_W-1:0];
                default: ;
            endcase
        end
    end

    // register readback
    always_comb begin
        unique case (cfg_idx)
            onre_pkg::REG_COEF_A:     prdata = onre_pkg::APB_DATA_W'(coef_a_reg);
            onre_pkg::REG_COEF_B:     prdata = onre_pkg::APB_DATA_W'(coef_b_reg);
            onre_pkg::REG_REFL_RED:   prdata = onre_pkg::APB_DATA_W'(refl_reg[0]);
            onre_pkg::REG_REFL_GREEN: prdata = onre_pkg::APB_DATA_W'(refl_reg[1]);
            onre_pkg::REG_REFL_BLUE:  prdata = onre_pkg::APB_DATA_W'(refl_reg[2]);
            default:                  prdata = '0;
        endcase
    end

    // ---------------- pipeline advance ----------------
    logic m_tvalid_reg;
    logic en;

    assign en       = !m_tvalid_reg || m_tready;
    assign s_tready = en;

    // ---------------- stage 1: clamp, products ----------------
    logic signed [onre_pkg::DIR_W-1:0] xi, yi, zi, xo, yo, zo;
    logic [ONE_W-1:0]  ci_c, co_c;
    logic              ok_c;

    assign xi = s_tdata[15:0];
    assign yi = s_tdata[31:16];
    assign zi = s_tdata[47:32];
    assign xo = s_tdata[63:48];
    assign yo = s_tdata[79:64];
    assign zo = s_tdata[95:80];

    always_comb begin
        ci_c = (ONE_W'(zi[onre_pkg::DIR_W-2:0]) > onre_pkg::ONE) ? onre_pkg::ONE
             : ONE_W'(zi[onre_pkg::DIR_W-2:0]);
        co_c = (ONE_W'(zo[onre_pkg::DIR_W-2:0]) > onre_pkg::ONE) ? onre_pkg::ONE
             : ONE_W'(zo[onre_pkg::DIR_W-2:0]);
        ok_c = s_tuser[0] && !zi[onre_pkg::DIR_W-1] && (zi != '0)
            && !zo[onre_pkg::DIR_W-1] && (zo != '0);
    end

    logic                                 v1_reg;
    logic signed [onre_pkg::PROD_W-1:0]   s1_xx_reg, s1_yy_reg;
    logic [onre_pkg::SQ_W-1:0]            s1_ci2_reg, s1_co2_reg;
    logic [ONE_W-1:0]                     s1_ci_reg, s1_co_reg;
    logic                                 s1_ok_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s1_xx_reg  <= xi * xo;
            s1_yy_reg  <= yi * yo;
            s1_ci2_reg <= ci_c * ci_c;
            s1_co2_reg <= co_c * co_c;
            s1_ci_reg  <= ci_c;
            s1_co_reg  <= co_c;
            s1_ok_reg  <= ok_c;
        end
    end

    // ---------------- stage 2: radicands, dot, density ----------------
    logic [onre_pkg::DSUM_W-1:0] dens_sum;
    logic [onre_pkg::DRAW_W-1:0] dens_raw;
    logic [VAL_W-1:0]            dens_c;

    always_comb begin
        dens_sum = onre_pkg::DSUM_W'(s1_co_reg * onre_pkg::INV_PI)
                 + (onre_pkg::DSUM_W'(1) << (onre_pkg::DEN_SHIFT - 1));
        dens_raw = onre_pkg::DRAW_W'(dens_sum >> onre_pkg::DEN_SHIFT);
        dens_c   = (dens_raw > onre_pkg::DRAW_W'(onre_pkg::VAL_MAX)) ? onre_pkg::VAL_MAX
                 : VAL_W'(dens_raw);
    end

    logic               v2_reg;
    logic [RAD_W-1:0]   s2_ri_reg, s2_ro_reg;
    onre_pkg::sq_side_t s2_side_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
        end else if (en) begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s2_ri_reg        <= RAD_W'(onre_pkg::ONE_SQ - s1_ci2_reg);
            s2_ro_reg        <= RAD_W'(onre_pkg::ONE_SQ - s1_co2_reg);
            s2_side_reg.ci   <= s1_ci_reg;
            s2_side_reg.co   <= s1_co_reg;
            s2_side_reg.dot  <= DOT_W'(s1_xx_reg) + DOT_W'(s1_yy_reg);
            s2_side_reg.dens <= dens_c;
            s2_side_reg.ok   <= s1_ok_reg;
        end
    end

    // ---------------- square-root chain ----------------
    logic               sq_v    [0:ROOT_W];
    logic [RAD_W-1:0]   sq_rem_a[0:ROOT_W];
    logic [ROOT_W-1:0]  sq_rt_a [0:ROOT_W];
    logic [RAD_W-1:0]   sq_rem_b[0:ROOT_W];
    logic [ROOT_W-1:0]  sq_rt_b [0:ROOT_W];
    onre_pkg::sq_side_t sq_side [0:ROOT_W];

    assign sq_v[0]     = v2_reg;
    assign sq_rem_a[0] = s2_ri_reg;
    assign sq_rt_a[0]  = '0;
    assign sq_rem_b[0] = s2_ro_reg;
    assign sq_rt_b[0]  = '0;
    assign sq_side[0]  = s2_side_reg;

    for (genvar j = 0; j < ROOT_W; j++) begin : g_sqrt
        onre_sqrt_cell #(
            .RAD_W  (RAD_W),
            .ROOT_W (ROOT_W),
            .K      (ROOT_W - 1 - j),
            .SIDE_T (onre_pkg::sq_side_t)
        ) u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .en         (en),
            .in_valid   (sq_v[j]),
            .in_rem_a   (sq_rem_a[j]),
            .in_root_a  (sq_rt_a[j]),
            .in_rem_b   (sq_rem_b[j]),
            .in_root_b  (sq_rt_b[j]),
            .in_side    (sq_side[j]),
            .out_valid  (sq_v[j+1]),
            .out_rem_a  (sq_rem_a[j+1]),
            .out_root_a (sq_rt_a[j+1]),
            .out_rem_b  (sq_rem_b[j+1]),
            .out_root_b (sq_rt_b[j+1]),
            .out_side   (sq_side[j+1])
        );
    end

    // ---------------- stage 3: sine products, alpha/beta choice ----------------
    logic [ROOT_W-1:0]  si, so, sa_c, st_c;
    logic [ONE_W-1:0]   ct_c;
    onre_pkg::sq_side_t sqo;

    assign si  = sq_rt_a[ROOT_W];
    assign so  = sq_rt_b[ROOT_W];
    assign sqo = sq_side[ROOT_W];

    always_comb begin
        if (sqo.ci > sqo.co) begin
            sa_c = so;
            st_c = si;
            ct_c = sqo.ci;
        end else begin
            sa_c = si;
            st_c = so;
            ct_c = sqo.co;
        end
    end

    logic                    v3_reg;
    logic [DP_W-1:0]         s3_d1_reg;
    logic [RAD_W-1:0]        s3_p_reg;
    logic [ONE_W-1:0]        s3_ct_reg, s3_co_reg;
    logic signed [DOT_W-1:0] s3_dot_reg;
    logic [VAL_W-1:0]        s3_dens_reg;
    logic                    s3_ok_reg, s3_cp_ok_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v3_reg <= 1'b0;
        end else if (en) begin
            v3_reg <= sq_v[ROOT_W];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s3_d1_reg    <= si * so;
            s3_p_reg     <= sa_c * st_c;
            s3_ct_reg    <= ct_c;
            s3_co_reg    <= sqo.co;
            s3_dot_reg   <= sqo.dot;
            s3_dens_reg  <= sqo.dens;
            s3_ok_reg    <= sqo.ok;
            s3_cp_ok_reg <= (si != '0) && (so != '0) && !sqo.dot[DOT_W-1] && (sqo.dot != '0);
        end
    end

    // ---------------- stage 4: dividends, saturation check ----------------
    localparam int SC_W = NP_W + 1;

    logic [NP_W-1:0] n1_c;

    assign n1_c = {s3_dot_reg[DOT_W-2:0], {F{1'b0}}};

    logic               v4_reg;
    logic [NP_W-1:0]    s4_n1_reg;
    logic [DP_W-1:0]    s4_d1_reg;
    logic [NQ_W-1:0]    s4_n2_reg;
    logic [DQ_W-1:0]    s4_ct_reg;
    onre_pkg::dv_side_t s4_side_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v4_reg <= 1'b0;
        end else if (en) begin
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s4_n1_reg         <= n1_c;
            s4_d1_reg         <= s3_d1_reg;
            s4_n2_reg         <= NQ_W'(s3_p_reg[RAD_W-1:F] * s3_co_reg);
            s4_ct_reg         <= s3_ct_reg;
            s4_side_reg.co    <= s3_co_reg;
            s4_side_reg.dens  <= s3_dens_reg;
            s4_side_reg.ok    <= s3_ok_reg;
            s4_side_reg.cp_ok <= s3_cp_ok_reg;
            s4_side_reg.sat   <= SC_W'(n1_c) >= SC_W'({s3_d1_reg, {QUO_W{1'b0}}});
        end
    end

    // ---------------- divider chain ----------------
    logic               dv_v   [0:QUO_W];
    logic [NP_W-1:0]    dv_ra  [0:QUO_W];
    logic [DP_W-1:0]    dv_da  [0:QUO_W];
    logic [QUO_W-1:0]   dv_qa  [0:QUO_W];
    logic [NQ_W-1:0]    dv_rb  [0:QUO_W];
    logic [DQ_W-1:0]    dv_db  [0:QUO_W];
    logic [QUO_W-1:0]   dv_qb  [0:QUO_W];
    onre_pkg::dv_side_t dv_side[0:QUO_W];

    assign dv_v[0]    = v4_reg;
    assign dv_ra[0]   = s4_n1_reg;
    assign dv_da[0]   = s4_d1_reg;
    assign dv_qa[0]   = '0;
    assign dv_rb[0]   = s4_n2_reg;
    assign dv_db[0]   = s4_ct_reg;
    assign dv_qb[0]   = '0;
    assign dv_side[0] = s4_side_reg;

    for (genvar j = 0; j < QUO_W; j++) begin : g_div
        onre_div_cell #(
            .NA_W   (NP_W),
            .DA_W   (DP_W),
            .NB_W   (NQ_W),
            .DB_W   (DQ_W),
            .Q_W    (QUO_W),
            .K      (QUO_W - 1 - j),
            .SIDE_T (onre_pkg::dv_side_t)
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (en),
            .in_valid  (dv_v[j]),
            .in_rem_a  (dv_ra[j]),
            .in_div_a  (dv_da[j]),
            .in_quo_a  (dv_qa[j]),
            .in_rem_b  (dv_rb[j]),
            .in_div_b  (dv_db[j]),
            .in_quo_b  (dv_qb[j]),
            .in_side   (dv_side[j]),
            .out_valid (dv_v[j+1]),
            .out_rem_a (dv_ra[j+1]),
            .out_div_a (dv_da[j+1]),
            .out_quo_a (dv_qa[j+1]),
            .out_rem_b (dv_rb[j+1]),
            .out_div_b (dv_db[j+1]),
            .out_quo_b (dv_qb[j+1]),
            .out_side  (dv_side[j+1])
        );
    end

    // ---------------- stage 5: clamp azimuth term, weight products ----------------
    onre_pkg::dv_side_t dvo;
    logic [ONE_W-1:0]   cp_c;
    logic [F-1:0]       w_c;

    assign dvo = dv_side[QUO_W];
    assign w_c = dv_qb[QUO_W][F-1:0];

    always_comb begin
        if (!dvo.cp_ok) begin
            cp_c = '0;
        end else if (dvo.sat || (dv_qa[QUO_W] > QUO_W'(onre_pkg::ONE))) begin
            cp_c = onre_pkg::ONE;
        end else begin
            cp_c = ONE_W'(dv_qa[QUO_W]);
        end
    end

    logic                       v5_reg;
    logic [onre_pkg::CPW_W-1:0] s5_cpw_reg;
    logic [onre_pkg::ACO_W-1:0] s5_aco_reg;
    onre_pkg::tail_t            s5_tail_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v5_reg <= 1'b0;
        end else if (en) begin
            v5_reg <= dv_v[QUO_W];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s5_cpw_reg       <= cp_c * w_c;
            s5_aco_reg       <= coef_a_reg * dvo.co;
            s5_tail_reg.dens <= dvo.dens;
            s5_tail_reg.ok   <= dvo.ok;
        end
    end

    // ---------------- stage 6: B term ----------------
    logic                       v6_reg;
    logic [onre_pkg::BT_W-1:0]  s6_bt_reg;
    logic [onre_pkg::ACO_W-1:0] s6_aco_reg;
    onre_pkg::tail_t            s6_tail_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v6_reg <= 1'b0;
        end else if (en) begin
            v6_reg <= v5_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s6_bt_reg   <= coef_b_reg * s5_cpw_reg[onre_pkg::CPW_W-1:F];
            s6_aco_reg  <= s5_aco_reg;
            s6_tail_reg <= s5_tail_reg;
        end
    end

    // ---------------- stage 7: A*co + B term, scale ----------------
    logic [onre_pkg::SUM_W-1:0] sum_c;
    logic                       v7_reg;
    logic [onre_pkg::R_W-1:0]   s7_r_reg;
    onre_pkg::tail_t            s7_tail_reg;

    assign sum_c = onre_pkg::SUM_W'(s6_aco_reg) + onre_pkg::SUM_W'(s6_bt_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v7_reg <= 1'b0;
        end else if (en) begin
            v7_reg <= v6_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s7_r_reg    <= sum_c[onre_pkg::SUM_W-1:F];
            s7_tail_reg <= s6_tail_reg;
        end
    end

    // ---------------- stage 8: reflectance products ----------------
    logic                      v8_reg;
    logic [onre_pkg::M1_W-1:0] s8_m1_reg [0:2];
    onre_pkg::tail_t           s8_tail_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v8_reg <= 1'b0;
        end else if (en) begin
            v8_reg <= v7_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < 3; k++) begin
                s8_m1_reg[k] <= refl_reg[k] * s7_r_reg;
            end
            s8_tail_reg <= s7_tail_reg;
        end
    end

    // ---------------- stage 9: times 1/pi ----------------
    logic                      v9_reg;
    logic [onre_pkg::M2_W-1:0] s9_m2_reg [0:2];
    onre_pkg::tail_t           s9_tail_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v9_reg <= 1'b0;
        end else if (en) begin
            v9_reg <= v8_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < 3; k++) begin
                s9_m2_reg[k] <= s8_m1_reg[k] * onre_pkg::INV_PI;
            end
            s9_tail_reg <= s8_tail_reg;
        end
    end

    // ---------------- output register: round, saturate, gate ----------------
    logic [onre_pkg::M2_W-1:0]   rnd_c [0:2];
    logic [onre_pkg::VRAW_W-1:0] vraw_c[0:2];
    logic [VAL_W-1:0]            val_c [0:2];
    logic [63:0]                 m_tdata_reg, m_tdata_next;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            rnd_c[k]  = s9_m2_reg[k]
                      + (onre_pkg::M2_W'(1) << (onre_pkg::VAL_SHIFT - 1));
            vraw_c[k] = onre_pkg::VRAW_W'(rnd_c[k] >> onre_pkg::VAL_SHIFT);
            val_c[k]  = (vraw_c[k] > onre_pkg::VRAW_W'(onre_pkg::VAL_MAX))
                      ? onre_pkg::VAL_MAX : VAL_W'(vraw_c[k]);
        end
        if (s9_tail_reg.ok) begin
            m_tdata_next = {s9_tail_reg.dens, val_c[2], val_c[1], val_c[0]};
        end else begin
            m_tdata_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (en) begin
            m_tvalid_reg <= v9_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_tdata_reg <= m_tdata_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // ---------------- assertions ----------------
    // zero density means a rejected item, so all color values are zero too
    a_zero_gate: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[63:48] == '0) |-> (m_tdata[47:0] == '0))
        else $error("color value nonzero on a rejected item");

    // the weight quotient never reaches one on an accepted item: co <= ct bounds it
    a_w_range: assert property (@(posedge aclk) disable iff (!aresetn)
        dv_v[QUO_W] && dvo.ok |-> !dv_qb[QUO_W][QUO_W-1])
        else $error("alpha/beta weight quotient out of range");

    // a held output freezes the whole pipeline
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |=> $stable(v5_reg) && $stable(v9_reg) && $stable(s9_tail_reg))
        else $error("pipeline moved while output was stalled");

endmodule

/* src/onre_sqrt_cell.sv */
// One bit step of the paired integer square-root chain.
module onre_sqrt_cell #(
    parameter int  RAD_W  = 30,
    parameter int  ROOT_W = 15,
    parameter int  K      = 0,
    parameter type SIDE_T = logic
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              en,
    input  logic              in_valid,
    input  logic [RAD_W-1:0]  in_rem_a,
    input  logic [ROOT_W-1:0] in_root_a,
    input  logic [RAD_W-1:0]  in_rem_b,
    input  logic [ROOT_W-1:0] in_root_b,
    input  SIDE_T             in_side,
    output logic              out_valid,
    output logic [RAD_W-1:0]  out_rem_a,
    output logic [ROOT_W-1:0] out_root_a,
    output logic [RAD_W-1:0]  out_rem_b,
    output logic [ROOT_W-1:0] out_root_b,
    output SIDE_T             out_side
);

    localparam int TW = RAD_W + 2;

    logic              valid_reg;
    logic [RAD_W-1:0]  rem_a_reg, rem_a_next, rem_b_reg, rem_b_next;
    logic [ROOT_W-1:0] root_a_reg, root_a_next, root_b_reg, root_b_next;
    SIDE_T             side_reg;
    logic [TW-1:0]     trial_a, trial_b;

    // (root + 2^K)^2 - root^2 = root*2^(K+1) + 4^K
    always_comb begin
        trial_a = (TW'(in_root_a) << (K + 1)) + (TW'(1) << (2 * K));
        trial_b = (TW'(in_root_b) << (K + 1)) + (TW'(1) << (2 * K));
        rem_a_next  = in_rem_a;
        root_a_next = in_root_a;
        rem_b_next  = in_rem_b;
        root_b_next = in_root_b;
        if (TW'(in_rem_a) >= trial_a) begin
            rem_a_next  = RAD_W'(TW'(in_rem_a) - trial_a);
            root_a_next = in_root_a | (ROOT_W'(1) << K);
        end
        if (TW'(in_rem_b) >= trial_b) begin
            rem_b_next  = RAD_W'(TW'(in_rem_b) - trial_b);
            root_b_next = in_root_b | (ROOT_W'(1) << K);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rem_a_reg  <= rem_a_next;
            root_a_reg <= root_a_next;
            rem_b_reg  <= rem_b_next;
            root_b_reg <= root_b_next;
            side_reg   <= in_side;
        end
    end

    assign out_valid  = valid_reg;
    assign out_rem_a  = rem_a_reg;
    assign out_root_a = root_a_reg;
    assign out_rem_b  = rem_b_reg;
    assign out_root_b = root_b_reg;
    assign out_side   = side_reg;

endmodule

/* src/onre_div_cell.sv */
// One quotient bit step of the paired restoring divider chain.
module onre_div_cell #(
    parameter int  NA_W   = 47,
    parameter int  DA_W   = 30,
    parameter int  NB_W   = 30,
    parameter int  DB_W   = 16,
    parameter int  Q_W    = 16,
    parameter int  K      = 0,
    parameter type SIDE_T = logic
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            en,
    input  logic            in_valid,
    input  logic [NA_W-1:0] in_rem_a,
    input  logic [DA_W-1:0] in_div_a,
    input  logic [Q_W-1:0]  in_quo_a,
    input  logic [NB_W-1:0] in_rem_b,
    input  logic [DB_W-1:0] in_div_b,
    input  logic [Q_W-1:0]  in_quo_b,
    input  SIDE_T           in_side,
    output logic            out_valid,
    output logic [NA_W-1:0] out_rem_a,
    output logic [DA_W-1:0] out_div_a,
    output logic [Q_W-1:0]  out_quo_a,
    output logic [NB_W-1:0] out_rem_b,
    output logic [DB_W-1:0] out_div_b,
    output logic [Q_W-1:0]  out_quo_b,
    output SIDE_T           out_side
);

    localparam int CA_W = (NA_W > DA_W + Q_W) ? NA_W : DA_W + Q_W;
    localparam int CB_W = (NB_W > DB_W + Q_W) ? NB_W : DB_W + Q_W;

    logic            valid_reg;
    logic [NA_W-1:0] rem_a_reg, rem_a_next;
    logic [NB_W-1:0] rem_b_reg, rem_b_next;
    logic [DA_W-1:0] div_a_reg;
    logic [DB_W-1:0] div_b_reg;
    logic [Q_W-1:0]  quo_a_reg, quo_a_next, quo_b_reg, quo_b_next;
    SIDE_T           side_reg;
    logic [CA_W-1:0] sh_a;
    logic [CB_W-1:0] sh_b;

    // subtract the shifted divisor where it fits
    always_comb begin
        sh_a = CA_W'(in_div_a) << K;
        sh_b = CB_W'(in_div_b) << K;
        rem_a_next = in_rem_a;
        quo_a_next = in_quo_a;
        rem_b_next = in_rem_b;
        quo_b_next = in_quo_b;
        if (CA_W'(in_rem_a) >= sh_a) begin
            rem_a_next = NA_W'(CA_W'(in_rem_a) - sh_a);
            quo_a_next = in_quo_a | (Q_W'(1) << K);
        end
        if (CB_W'(in_rem_b) >= sh_b) begin
            rem_b_next = NB_W'(CB_W'(in_rem_b) - sh_b);
            quo_b_next = in_quo_b | (Q_W'(1) << K);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rem_a_reg <= rem_a_next;
            div_a_reg <= in_div_a;
            quo_a_reg <= quo_a_next;
            rem_b_reg <= rem_b_next;
            div_b_reg <= in_div_b;
            quo_b_reg <= quo_b_next;
            side_reg  <= in_side;
        end
    end

    assign out_valid = valid_reg;
    assign out_rem_a = rem_a_reg;
    assign out_div_a = div_a_reg;
    assign out_quo_a = quo_a_reg;
    assign out_rem_b = rem_b_reg;
    assign out_div_b = div_b_reg;
    assign out_quo_b = quo_b_reg;
    assign out_side  = side_reg;

endmodule
